// File: design/ssrch_pkg.sv
`default_nettype none

package ssrch_pkg;

  // widths fixed by the item format
  localparam int CHAR_W      = 8;
  localparam int POS_W       = 32;
  localparam int MAX_PATTERN = 64;

  localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

  // operation codes
  localparam logic OP_PATTERN = 1'b0;
  localparam logic OP_TEXT    = 1'b1;

  // controller -> datapath commands
  typedef struct packed {
    logic accept;   // take the word on the input ports
    logic compare;  // compare the bytes read in the previous cycle
    logic report;   // publish the result, clear the text state
  } ctl_t;

  // datapath -> controller status
  typedef struct packed {
    logic scan_needed;  // accepted text byte needs a window compare
    logic report_req;   // accepted word ends the text
    logic scan_end;     // compare step finished the scan
  } sts_t;

  // ASCII upper to lower case when folding
  function automatic logic [CHAR_W-1:0] fold_byte(input logic fold,
                                                  input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] r;
    r = c;
    if (fold && c >= 8'h41 && c <= 8'h5A) begin
      r = c + 8'h20;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: design/ssrch_ctrl.sv
`default_nettype none

module ssrch_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  output logic               busy,
  output ssrch_pkg::ctl_t    ctl,
  input  wire ssrch_pkg::sts_t sts
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_COMPARE,
    S_REPORT
  } state_t;

  state_t state;
  logic   pend;  // text ended, result due after the scan

  // state and pending flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pend  <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            pend <= sts.report_req;
            if (sts.scan_needed) begin
              state <= S_READ;
            end else if (sts.report_req) begin
              state <= S_REPORT;
            end
          end
        end
        S_READ: begin
          state <= S_COMPARE;
        end
        S_COMPARE: begin
          if (!sts.scan_end) begin
            state <= S_READ;
          end else if (pend) begin
            state <= S_REPORT;
          end else begin
            state <= S_IDLE;
          end
        end
        S_REPORT: begin
          state <= S_IDLE;
          pend  <= 1'b0;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // commands
  always_comb begin
    busy        = (state != S_IDLE);
    ctl.accept  = (state == S_IDLE) && start;
    ctl.compare = (state == S_COMPARE);
    ctl.report  = (state == S_REPORT);
  end

endmodule

`default_nettype wire

// File: design/ssrch_dp.sv
`default_nettype none

module ssrch_dp #(
  parameter int MAX_PATTERN = ssrch_pkg::MAX_PATTERN
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire ssrch_pkg::ctl_t               ctl,
  output ssrch_pkg::sts_t                    sts,
  input  wire logic                          cfg_write,
  input  wire logic                          cfg_data,
  input  wire logic                          operation,
  input  wire logic [ssrch_pkg::CHAR_W-1:0]  ch,
  input  wire logic                          last,
  input  wire logic                          no_char,
  output logic                               done,
  output logic                               found,
  output logic [ssrch_pkg::POS_W-1:0]        position
);

  localparam int AW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int LW = $clog2(MAX_PATTERN + 1);
  localparam logic [LW-1:0] LEN_MAX = LW'(MAX_PATTERN);
  localparam logic [AW-1:0] ADDR_TOP = AW'(MAX_PATTERN - 1);

  // memories
  logic [ssrch_pkg::CHAR_W-1:0] pmem [MAX_PATTERN];
  logic [ssrch_pkg::CHAR_W-1:0] wmem [MAX_PATTERN];
  logic [ssrch_pkg::CHAR_W-1:0] p_rdata, w_rdata;

  // registers
  logic                       case_fold;
  logic [LW-1:0]              pattern_length;
  logic [LW-1:0]              first_zero;
  logic                       zero_seen;
  logic                       pattern_loading;
  logic [ssrch_pkg::POS_W-1:0] text_count;
  logic                       match_seen;
  logic [ssrch_pkg::POS_W-1:0] match_offset;
  logic                       term_seen;
  logic [AW-1:0]              wptr;
  logic [AW-1:0]              paddr;
  logic [AW-1:0]              waddr;

  // decode
  logic [LW-1:0]              eff_len;
  logic [LW-1:0]              base_len;
  logic                       zs_base;
  logic                       store_en;
  logic [ssrch_pkg::POS_W-1:0] count_next;
  logic [AW-1:0]              wptr_next;
  logic [LW:0]                win_base;
  logic                       text_byte;
  logic                       is_term;
  logic                       bytes_eq;
  logic                       last_step;

  always_comb begin
    eff_len   = (case_fold && zero_seen) ? first_zero : pattern_length;
    base_len  = pattern_loading ? pattern_length : '0;
    zs_base   = pattern_loading && zero_seen;
    store_en  = !no_char && (base_len < LEN_MAX);
    count_next = (text_count == ssrch_pkg::POS_MAX) ? text_count : text_count + 1'b1;
    wptr_next = (wptr == ADDR_TOP) ? '0 : wptr + 1'b1;
    // oldest byte of the compared window in the ring
    if ((LW+1)'(wptr_next) >= (LW+1)'(eff_len)) begin
      win_base = (LW+1)'(wptr_next) - (LW+1)'(eff_len);
    end else begin
      win_base = (LW+1)'(wptr_next) + (LW+1)'(MAX_PATTERN) - (LW+1)'(eff_len);
    end
    text_byte = (operation == ssrch_pkg::OP_TEXT) && !no_char && !(case_fold && term_seen);
    is_term   = case_fold && (ch == '0);
    bytes_eq  = ssrch_pkg::fold_byte(case_fold, p_rdata)
             == ssrch_pkg::fold_byte(case_fold, w_rdata);
    last_step = (LW'(paddr) == eff_len - 1'b1);

    sts.scan_needed = text_byte && !is_term && !match_seen && (eff_len != '0)
                   && (count_next >= ssrch_pkg::POS_W'(eff_len));
    sts.report_req  = (operation == ssrch_pkg::OP_TEXT) && last;
    sts.scan_end    = !bytes_eq || last_step;
  end

  // pattern store and text ring, registered reads
  always_ff @(posedge clk) begin
    if (ctl.accept && operation == ssrch_pkg::OP_PATTERN && store_en) begin
      pmem[base_len[AW-1:0]] <= ch;
    end
    if (ctl.accept && text_byte && !is_term) begin
      wmem[wptr] <= ch;
    end
    p_rdata <= pmem[paddr];
    w_rdata <= wmem[waddr];
  end

  // config register
  always_ff @(posedge clk) begin
    if (rst) begin
      case_fold <= 1'b0;
    end else if (cfg_write) begin
      case_fold <= cfg_data;
    end
  end

  // search state
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length  <= '0;
      first_zero      <= '0;
      zero_seen       <= 1'b0;
      pattern_loading <= 1'b1;
      text_count      <= '0;
      match_seen      <= 1'b0;
      match_offset    <= '0;
      term_seen       <= 1'b0;
      wptr            <= '0;
      done            <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctl.accept) begin
        if (operation == ssrch_pkg::OP_PATTERN) begin
          // a pattern word after a finished pattern starts over
          if (!pattern_loading) begin
            text_count   <= '0;
            match_seen   <= 1'b0;
            match_offset <= '0;
            term_seen    <= 1'b0;
            wptr         <= '0;
          end
          if (store_en) begin
            pattern_length <= base_len + 1'b1;
          end else begin
            pattern_length <= base_len;
          end
          if (store_en && !zs_base && ch == '0) begin
            zero_seen  <= 1'b1;
            first_zero <= base_len;
          end else begin
            zero_seen  <= zs_base;
          end
          pattern_loading <= !last;
        end else begin
          pattern_loading <= 1'b0;
          if (text_byte) begin
            if (is_term) begin
              term_seen <= 1'b1;
            end else begin
              wptr       <= wptr_next;
              text_count <= count_next;
              if (!match_seen && eff_len == '0 && case_fold) begin
                match_seen   <= 1'b1;
                match_offset <= '0;
              end
            end
          end
        end
      end else if (ctl.compare) begin
        if (bytes_eq && last_step) begin
          match_seen   <= 1'b1;
          match_offset <= text_count - ssrch_pkg::POS_W'(eff_len);
        end
      end else if (ctl.report) begin
        done         <= 1'b1;
        text_count   <= '0;
        match_seen   <= 1'b0;
        match_offset <= '0;
        term_seen    <= 1'b0;
        wptr         <= '0;
      end
    end
  end

  // scan addresses
  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      paddr <= '0;
      waddr <= win_base[AW-1:0];
    end else if (ctl.compare) begin
      paddr <= paddr + 1'b1;
      waddr <= (waddr == ADDR_TOP) ? '0 : waddr + 1'b1;
    end
  end

  // result word
  always_ff @(posedge clk) begin
    if (ctl.report) begin
      found    <= match_seen || (!case_fold && eff_len == '0);
      position <= match_offset;
    end
  end

endmodule

`default_nettype wire

// File: design/substring_search.sv
// Channel   Ports                                   Handshake
// config    cfg_write, cfg_data                     written when cfg_write is high
// input     operation, ch, last, no_char            taken when start & !busy
// result    found, position                         valid for one cycle with done
//
// A pattern word, or a text word that needs no window compare, is taken in S_IDLE.
// A text byte that needs a compare runs S_READ then S_COMPARE for each of up to
// pattern-length steps: each step reads one pattern byte and one ring byte through a
// single read port on each memory, and the scan stops at the first mismatch.
// A word that ends the text then passes through S_REPORT to publish the result.
// Synchronous reset clears all control state; the receiver cannot stall.
`default_nettype none

module substring_search #(
  parameter int MAX_PATTERN = ssrch_pkg::MAX_PATTERN
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_write,
  input  wire logic                          cfg_data,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic                          operation,
  input  wire logic [ssrch_pkg::CHAR_W-1:0]  ch,
  input  wire logic                          last,
  input  wire logic                          no_char,
  output logic                               done,
  output logic                               found,
  output logic [ssrch_pkg::POS_W-1:0]        position
);

  ssrch_pkg::ctl_t ctl;
  ssrch_pkg::sts_t sts;

  // sequencer
  ssrch_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .ctl   (ctl),
    .sts   (sts)
  );

  // memories, counters, compare
  ssrch_dp #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .sts       (sts),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .operation (operation),
    .ch        (ch),
    .last      (last),
    .no_char   (no_char),
    .done      (done),
    .found     (found),
    .position  (position)
  );

endmodule

`default_nettype wire

// File: dv/tb.sv
`timescale 1ns / 100ps

module tb;

  localparam int CHAR_W      = ssrch_pkg::CHAR_W;
  localparam int POS_W       = ssrch_pkg::POS_W;
  localparam int MAX_PATTERN = ssrch_pkg::MAX_PATTERN;
  localparam logic [POS_W-1:0] POS_MAX = ssrch_pkg::POS_MAX;
  localparam logic OP_PATTERN = ssrch_pkg::OP_PATTERN;
  localparam logic OP_TEXT    = ssrch_pkg::OP_TEXT;

  localparam int LIMIT_CYCLES = 1_000_000;
  // drain covers the longest compare scan plus the publish step
  localparam int DRAIN_CYCLES = 2 * MAX_PATTERN + 12;
  localparam int RANDOM_WORDS = 550;

  typedef struct {
    logic             found;
    logic [POS_W-1:0] position;
  } report_t;

  typedef enum logic {ROW_WORD, ROW_FOLD} row_kind_t;

  typedef struct {
    row_kind_t         kind;
    logic              op;
    logic [CHAR_W-1:0] c;
    logic              lst;
    logic              nc;
    logic              typed;
    logic              tf;
    logic [POS_W-1:0]  tp;
  } dir_row_t;

  logic              clk;
  logic              rst;
  logic              cfg_write;
  logic              cfg_data;
  logic              start;
  logic              busy;
  logic              operation;
  logic [CHAR_W-1:0] ch;
  logic              last;
  logic              no_char;
  logic              done;
  logic              found;
  logic [POS_W-1:0]  position;

  // hand-typed expectation that travels with the current word
  logic              hint_valid;
  logic              hint_found;
  logic [POS_W-1:0]  hint_pos;

  // search model state
  logic              fold_mode;
  logic [CHAR_W-1:0] pat_mem [MAX_PATTERN];
  int                pat_len;
  logic [CHAR_W-1:0] win [MAX_PATTERN];
  logic [POS_W-1:0]  txt_count;
  logic [POS_W-1:0]  hit_pos;
  bit                hit_seen;
  bit                pat_open;
  bit                nul_seen;

  report_t           expected_reports[$];
  dir_row_t          dir_q[$];
  int                errors;
  int                words_sent;
  longint            cycles;
  bit                steady;

  substring_search dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .start     (start),
    .busy      (busy),
    .operation (operation),
    .ch        (ch),
    .last      (last),
    .no_char   (no_char),
    .done      (done),
    .found     (found),
    .position  (position)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------
  // search model
  // ---------------------------------------------------------------
  function automatic logic [CHAR_W-1:0] fold_char(input logic [CHAR_W-1:0] c);
    if (fold_mode && c >= 8'h41 && c <= 8'h5A) begin
      return c + 8'h20;
    end
    return c;
  endfunction

  // folded mode: pattern ends at its first zero byte
  function automatic int active_len();
    for (int i = 0; i < pat_len; i++) begin
      if (fold_mode && pat_mem[i] == 8'h00) begin
        return i;
      end
    end
    return pat_len;
  endfunction

  function automatic void clear_text();
    for (int i = 0; i < MAX_PATTERN; i++) begin
      win[i] = '0;
    end
    txt_count = '0;
    hit_seen  = 1'b0;
    hit_pos   = '0;
    nul_seen  = 1'b0;
  endfunction

  function automatic void reset_model();
    fold_mode = 1'b0;
    pat_len   = 0;
    pat_open  = 1'b1;
    clear_text();
  endfunction

  // shift one text byte into the window and look for the first hit
  function automatic void shift_text(input logic [CHAR_W-1:0] c);
    int len;
    bit hit;
    len = active_len();
    if (fold_mode && nul_seen) begin
      return;
    end
    if (fold_mode && c == 8'h00) begin
      nul_seen = 1'b1;
      return;
    end
    for (int i = 0; i < MAX_PATTERN - 1; i++) begin
      win[i] = win[i+1];
    end
    win[MAX_PATTERN-1] = c;
    if (txt_count != POS_MAX) begin
      txt_count = txt_count + 1;
    end
    if (hit_seen) begin
      return;
    end
    if (len == 0) begin
      if (fold_mode) begin
        hit_seen = 1'b1;
        hit_pos  = '0;
      end
      return;
    end
    if (txt_count < len) begin
      return;
    end
    hit = 1'b1;
    for (int i = 0; i < len; i++) begin
      if (fold_char(win[MAX_PATTERN-len+i]) != fold_char(pat_mem[i])) begin
        hit = 1'b0;
      end
    end
    if (hit) begin
      hit_seen = 1'b1;
      hit_pos  = txt_count - len;
    end
  endfunction

  // returns 1 when the word ends a text and produces a report
  function automatic bit predict_search(input logic op, input logic [CHAR_W-1:0] c,
                                        input logic lst, input logic nc,
                                        output report_t rep);
    rep.found    = 1'b0;
    rep.position = '0;
    if (op == OP_PATTERN) begin
      if (!pat_open) begin
        pat_len  = 0;
        pat_open = 1'b1;
        clear_text();
      end
      if (!nc && pat_len < MAX_PATTERN) begin
        pat_mem[pat_len] = c;
        pat_len++;
      end
      if (lst) begin
        pat_open = 1'b0;
      end
      return 1'b0;
    end
    pat_open = 1'b0;
    if (!nc) begin
      shift_text(c);
    end
    if (!lst) begin
      return 1'b0;
    end
    if (hit_seen) begin
      rep.found    = 1'b1;
      rep.position = hit_pos;
    end else if (!fold_mode && active_len() == 0) begin
      rep.found = 1'b1;
    end
    clear_text();
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------
  // scoreboard: predict on accept, then check any result this edge
  // ---------------------------------------------------------------
  always @(posedge clk) begin
    report_t rep;
    report_t want;
    if (rst) begin
      reset_model();
    end else begin
      if (cfg_write) begin
        fold_mode = cfg_data;
      end
      if (start && !busy) begin
        if (predict_search(operation, ch, last, no_char, rep)) begin
          if (hint_valid) begin
            rep.found    = hint_found;
            rep.position = hint_pos;
          end
          expected_reports.push_back(rep);
        end
      end
      if (done) begin
        if (expected_reports.size() == 0) begin
          $display("%0t: unexpected result found=%0d position=%0d", $time, found, position);
          errors++;
        end else begin
          want = expected_reports.pop_front();
          if (found !== want.found) begin
            $display("%0t: found expected %0d actual %0d", $time, want.found, found);
            errors++;
          end
          if (position !== want.position) begin
            $display("%0t: position expected %0d actual %0d", $time, want.position,
                     position);
            errors++;
          end
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("simulation failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------
  // driver
  // ---------------------------------------------------------------
  task automatic send_word(input logic op, input logic [CHAR_W-1:0] c, input logic lst,
                           input logic nc, input logic typed, input logic tf,
                           input logic [POS_W-1:0] tp);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start      <= 1'b1;
    operation  <= op;
    ch         <= c;
    last       <= lst;
    no_char    <= nc;
    hint_valid <= typed;
    hint_found <= tf;
    hint_pos   <= tp;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (!nc || lst) begin
      words_sent++;
    end
  endtask

  // hold off until every report is in and the block has gone quiet
  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_fold(input logic v);
    settle();
    cfg_write <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  function automatic dir_row_t row(input row_kind_t k, input logic op,
                                   input logic [CHAR_W-1:0] c, input logic lst,
                                   input logic nc, input logic typed, input logic tf,
                                   input logic [POS_W-1:0] tp);
    dir_row_t r;
    r.kind  = k;
    r.op    = op;
    r.c     = c;
    r.lst   = lst;
    r.nc    = nc;
    r.typed = typed;
    r.tf    = tf;
    r.tp    = tp;
    return r;
  endfunction

  // small alphabet so that hits happen, with zero and edge-of-range letters
  function automatic logic [CHAR_W-1:0] pick_sym();
    case ($urandom_range(0, 11))
      0, 1, 2: return 8'h61;
      3, 4:    return 8'h62;
      5:       return 8'h41;
      6:       return 8'h42;
      7:       return 8'h00;
      8:       return 8'($urandom_range(0, 255));
      9:       return 8'h5A;
      10:      return 8'h7A;
      default: return $urandom_range(0, 1) ? 8'h40 : 8'h5B;
    endcase
  endfunction

  // one pattern, then a few texts that often carry a copy of it
  task automatic run_search();
    logic [CHAR_W-1:0] pat[$];
    logic [CHAR_W-1:0] txt[$];
    logic [CHAR_W-1:0] b;
    int plen;
    int tlen;
    int at;
    int sz;
    bit open_end;
    bit nc_close;
    sz = $urandom_range(0, 99);
    plen = (sz < 4) ? $urandom_range(60, 70) :
           (sz < 15) ? $urandom_range(7, 16) : $urandom_range(0, 6);
    for (int i = 0; i < plen; i++) begin
      pat.push_back(pick_sym());
    end
    // open_end: text arrives while the pattern is still loading
    open_end = ($urandom_range(0, 9) == 0);
    nc_close = ($urandom_range(0, 4) == 0);
    for (int i = 0; i < plen; i++) begin
      if ($urandom_range(0, 19) == 0) begin
        send_word(OP_PATTERN, 8'($urandom_range(0, 255)), 1'b0, 1'b1, 1'b0, 1'b0, '0);
      end
      send_word(OP_PATTERN, pat[i], (i == plen - 1) && !open_end && !nc_close, 1'b0,
                1'b0, 1'b0, '0);
    end
    if (!open_end && (plen == 0 || nc_close)) begin
      send_word(OP_PATTERN, 8'($urandom_range(0, 255)), 1'b1, 1'b1, 1'b0, 1'b0, '0);
    end

    repeat ($urandom_range(1, 3)) begin
      txt.delete();
      tlen = $urandom_range(0, 12) + ((plen > 16) ? plen : $urandom_range(0, 4));
      for (int i = 0; i < tlen; i++) begin
        txt.push_back(pick_sym());
      end
      if (tlen >= plen && $urandom_range(0, 9) < 6) begin
        at = $urandom_range(0, tlen - plen);
        for (int i = 0; i < plen; i++) begin
          b = pat[i];
          if ((b | 8'h20) >= 8'h61 && (b | 8'h20) <= 8'h7A && $urandom_range(0, 3) == 0) begin
            b = b ^ 8'h20;
          end
          txt[at+i] = b;
        end
      end
      nc_close = (tlen == 0) || ($urandom_range(0, 3) == 0);
      for (int i = 0; i < tlen; i++) begin
        if ($urandom_range(0, 19) == 0) begin
          send_word(OP_TEXT, 8'($urandom_range(0, 255)), 1'b0, 1'b1, 1'b0, 1'b0, '0);
        end
        send_word(OP_TEXT, txt[i], (i == tlen - 1) && !nc_close, 1'b0, 1'b0, 1'b0, '0);
      end
      if (nc_close) begin
        send_word(OP_TEXT, 8'($urandom_range(0, 255)), 1'b1, 1'b1, 1'b0, 1'b0, '0);
      end
    end
  endtask

  // unstructured words: any op, any byte, stray ends
  task automatic noise_burst();
    repeat ($urandom_range(1, 8)) begin
      send_word(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                $urandom_range(0, 3) == 0, $urandom_range(0, 9) == 0, 1'b0, 1'b0, '0);
    end
  endtask

  // ---------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------
  initial begin
    rst        = 1'b1;
    cfg_write  = 1'b0;
    cfg_data   = 1'b0;
    start      = 1'b0;
    operation  = OP_PATTERN;
    ch         = '0;
    last       = 1'b0;
    no_char    = 1'b0;
    hint_valid = 1'b0;
    hint_found = 1'b0;
    hint_pos   = '0;
    errors     = 0;
    words_sent = 0;
    cycles     = 0;
    steady     = 1'b0;

    // exact mode: empty pattern hits even an empty text
    dir_q.push_back(row(ROW_WORD, OP_TEXT,    8'h00, 1'b1, 1'b1, 1'b1, 1'b1, 0));
    // pattern with embedded zero and 0xFF
    dir_q.push_back(row(ROW_WORD, OP_PATTERN, 8'h61, 1'b0, 1'b0, 1'b0, 1'b0, 0));
    dir_q.push_back(row(ROW_WORD, OP_PATTERN, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 0));
    dir_q.push_back(row(ROW_WORD, OP_PATTERN, 8'hFF, 1'b1, 1'b0, 1'b0, 1'b0, 0));
    dir_q.push_back(row(ROW_WORD, OP_TEXT,    8'hFF, 1'b0, 1'b0, 1'b0, 1'b0, 0));
    dir_q.push_back(row(ROW_WORD, OP_TEXT,    8'h61, 1'b0, 1'b0, 1'b0, 1'b0, 0));
    dir_q.push_back(row(ROW_WORD, OP_TEXT,    8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 0));
    dir_q.push_back(row(ROW_WORD, OP_TEXT,    8'hFF, 1'b1, 1'b0, 1'b1, 1'b1, 1));
    dir_q.push_back(row(ROW_WORD, OP_TEXT,    8'h41, 1'b1, 1'b0, 1'b1, 1'b0, 0));
    // folded mode: pattern now ends at the zero byte
    dir_q.push_back(row(ROW_FOLD, OP_TEXT,    8'h01, 1'b0, 1'b0, 1'b0, 1'b0, 0));
    dir_q.push_back(row(ROW_WORD, OP_TEXT,    8'h00, 1'b1, 1'b1, 1'b1, 1'b0, 0));
    dir_q.push_back(row(ROW_WORD, OP_TEXT,    8'h58, 1'b0, 1'b0, 1'b0, 1'b0, 0));
    dir_q.push_back(row(ROW_WORD, OP_TEXT,    8'h41, 1'b1, 1'b0, 1'b1, 1'b1, 1));
    // zero byte terminates the text
    dir_q.push_back(row(ROW_WORD, OP_TEXT,    8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 0));
    dir_q.push_back(row(ROW_WORD, OP_TEXT,    8'h61, 1'b1, 1'b0, 1'b1, 1'b0, 0));
    // new empty pattern, folded: hit only on a nonzero first byte
    dir_q.push_back(row(ROW_WORD, OP_PATTERN, 8'h00, 1'b1, 1'b1, 1'b0, 1'b0, 0));
    dir_q.push_back(row(ROW_WORD, OP_TEXT,    8'h5A, 1'b1, 1'b0, 1'b1, 1'b1, 0));
    dir_q.push_back(row(ROW_WORD, OP_TEXT,    8'h00, 1'b1, 1'b0, 1'b1, 1'b0, 0));
    // text cuts the pattern short
    dir_q.push_back(row(ROW_WORD, OP_PATTERN, 8'h42, 1'b0, 1'b0, 1'b0, 1'b0, 0));
    dir_q.push_back(row(ROW_WORD, OP_TEXT,    8'h62, 1'b1, 1'b0, 1'b1, 1'b1, 0));
    // word without a byte, then a non-letter just past Z
    dir_q.push_back(row(ROW_WORD, OP_TEXT,    8'h7F, 1'b0, 1'b1, 1'b0, 1'b0, 0));
    dir_q.push_back(row(ROW_WORD, OP_TEXT,    8'h5B, 1'b1, 1'b0, 1'b1, 1'b0, 0));
    dir_q.push_back(row(ROW_FOLD, OP_TEXT,    8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 0));

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed table
    foreach (dir_q[i]) begin
      if (dir_q[i].kind == ROW_FOLD) begin
        write_fold(dir_q[i].c[0]);
      end else begin
        send_word(dir_q[i].op, dir_q[i].c, dir_q[i].lst, dir_q[i].nc, dir_q[i].typed,
                  dir_q[i].tf, dir_q[i].tp);
      end
    end

    // random traffic, mode flipped now and then
    words_sent = 0;
    write_fold(1'b1);
    while (words_sent < RANDOM_WORDS) begin
      steady = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 11) == 0) begin
        write_fold(1'($urandom_range(0, 1)));
      end
      if ($urandom_range(0, 3) == 0) begin
        noise_burst();
      end else begin
        run_search();
      end
    end

    settle();
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
design/ssrch_pkg.sv
design/ssrch_ctrl.sv
design/ssrch_dp.sv
design/substring_search.sv
dv/tb.sv
